[design/wrs_pkg.sv]
// Package for the water ripple stencil step: payload structs, register
// indexes and the cell job type shared by the front and back parts.
// No dependencies.
package wrs_pkg;

  localparam int MaxWidth  = 1024;
  localparam int MaxHeight = 4096;
  localparam int ColW      = 10;
  localparam int RowW      = 12;

  typedef enum logic [1:0] {
    REG_GRID_WIDTH  = 2'd0,
    REG_GRID_HEIGHT = 2'd1,
    REG_DAMPING     = 2'd2,
    REG_BANK_MODE   = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic signed [15:0] cur_height;
    logic signed [15:0] prev_height;
    logic [7:0]         bank_alpha;
  } in_item_t;

  typedef struct packed {
    logic [9:0]         out_col;
    logic [11:0]        out_row;
    logic signed [15:0] new_height;
    logic               last_in_run;
    logic               end_of_frame;
  } out_item_t;

  // One cell job handed from the front part to the back part.
  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic signed [15:0] up;
    logic signed [15:0] down;
    logic signed [15:0] prev;
    logic [7:0]         alpha;
    logic [ColW-1:0]    col;
    logic [RowW-1:0]    row;
    logic               last;
    logic               eof;
  } job_t;

endpackage

[design/wrs_front.sv]
// Front part: tracks the raster position, keeps the line stores and emits
// up to three cell jobs per accepted cell. Depends on wrs_pkg.
module wrs_front import wrs_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  in_item_t        in_data,
  input  logic [10:0]     eff_w,
  input  logic [12:0]     eff_h,
  input  logic            restart,
  output logic            job_valid,
  input  logic            job_ready,
  output job_t            job
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RD   = 4'b0010,
    S_J0   = 4'b0100,
    S_J1   = 4'b1000
  } st_t;

  logic [15:0] upper_mem [MaxWidth];
  logic [15:0] mid_mem   [MaxWidth];
  logic [15:0] prev_mem  [MaxWidth];
  logic [7:0]  alpha_mem [MaxWidth];

  st_t             st_r, st_nxt;
  logic [ColW-1:0] col_r;
  logic [RowW-1:0] row_r;
  logic [15:0]     left_mid_r;
  in_item_t        item_r;
  logic [ColW-1:0] c_r;
  logic [RowW-1:0] r_r;
  // registered store reads
  logic [15:0] rd_up_c, rd_mid_c, rd_mid_c1, rd_mid_cm2;
  logic [15:0] rd_prev_c, rd_prev_cm1, rd_up_cm1;
  logic [7:0]  rd_al_c, rd_al_cm1;
  logic [15:0] mid_cm1_hold_r;
  logic [1:0]  jsel_r;

  logic [ColW-1:0] c_in;
  logic [RowW-1:0] r_in;
  logic            wrap;
  logic            last_row, first_col, last_col;
  logic [ColW:0]   wm1;
  logic [RowW:0]   hm1;

  assign wm1 = eff_w - 11'd1;
  assign hm1 = eff_h - 13'd1;
  assign wrap = ({1'b0, col_r} >= eff_w) || ({1'b0, row_r} >= eff_h);
  assign c_in = wrap ? '0 : col_r;
  assign r_in = wrap ? '0 : row_r;

  assign in_ready = (st_r == S_IDLE);
  assign last_row  = ({1'b0, r_r} == hm1);
  assign first_col = (c_r == '0);
  assign last_col  = ({1'b0, c_r} == wm1);

  // Jobs: jsel 0 = row above (r-1,c); 1 = (r,c-1); 2 = (r,c) at frame end.
  logic has0, has1, has2;
  assign has0 = (r_r != '0);
  assign has1 = last_row && !first_col;
  assign has2 = last_row && last_col;

  // Stores are read at the incoming column on accept and at the columns to its
  // left in S_RD, written when S_J0 is left, whether or not the item has a job there.
  always_ff @(posedge clk) begin
    if (st_r == S_IDLE && in_valid) begin
      rd_up_c    <= upper_mem[c_in];
      rd_mid_c   <= mid_mem[c_in];
      rd_prev_c  <= prev_mem[c_in];
      rd_al_c    <= alpha_mem[c_in];
      rd_mid_c1  <= mid_mem[c_in + ColW'(1)];
    end
    if (st_r == S_RD) begin
      rd_up_cm1   <= upper_mem[c_r - ColW'(1)];
      rd_prev_cm1 <= prev_mem[c_r - ColW'(1)];
      rd_al_cm1   <= alpha_mem[c_r - ColW'(1)];
      rd_mid_cm2  <= mid_mem[c_r - ColW'(2)];
    end
    if (st_r == S_J0 && (!has0 || job_ready)) begin
      upper_mem[c_r] <= (r_r == '0) ? 16'd0 : rd_mid_c;
      mid_mem[c_r]   <= item_r.cur_height;
      prev_mem[c_r]  <= item_r.prev_height;
      alpha_mem[c_r] <= item_r.bank_alpha;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == S_IDLE && in_valid) begin
      item_r <= in_data;
      c_r    <= c_in;
      r_r    <= r_in;
    end
    if (st_r == S_RD) mid_cm1_hold_r <= mid_mem[c_r - ColW'(1)];
  end

  always_comb begin
    job = '0;
    unique case (jsel_r)
      2'd0: begin
        job.left  = first_col ? 16'sd0 : left_mid_r;
        job.right = last_col ? 16'sd0 : rd_mid_c1;
        job.up    = rd_up_c;
        job.down  = item_r.cur_height;
        job.prev  = rd_prev_c;
        job.alpha = rd_al_c;
        job.col   = c_r;
        job.row   = r_r - RowW'(1);
        job.last  = !has1 && !has2;
      end
      2'd1: begin
        job.left  = (c_r >= ColW'(2)) ? rd_mid_cm2 : 16'sd0;
        job.right = item_r.cur_height;
        job.up    = rd_up_cm1;
        job.prev  = rd_prev_cm1;
        job.alpha = rd_al_cm1;
        job.col   = c_r - ColW'(1);
        job.row   = r_r;
        job.last  = !has2;
      end
      default: begin
        job.left  = (r_r == '0) ? 16'sd0 : mid_cm1_hold_r;
        job.up    = (r_r == '0) ? 16'sd0 : rd_mid_c;
        job.prev  = item_r.prev_height;
        job.alpha = item_r.bank_alpha;
        job.col   = c_r;
        job.row   = r_r;
        job.last  = 1'b1;
        job.eof   = 1'b1;
      end
    endcase
  end
  // Items with no job at all still pass through S_J0 for the store write.
  assign job_valid = (st_r == S_J0 && jsel_r == 2'd0 && has0) ||
                     (st_r == S_J1);

  logic [1:0] jsel_nxt;

  always_comb begin
    st_nxt   = st_r;
    jsel_nxt = jsel_r;
    priority case (st_r)
      S_IDLE: if (in_valid) st_nxt = S_RD;
      S_RD: begin
        st_nxt = S_J0; jsel_nxt = 2'd0;
      end
      S_J0: if (!has0 || job_ready) begin
        if (has1) begin st_nxt = S_J1; jsel_nxt = 2'd1; end
        else if (has2) begin st_nxt = S_J1; jsel_nxt = 2'd2; end
        else st_nxt = S_IDLE;
      end
      S_J1: if (job_ready) begin
        if (jsel_r == 2'd1 && has2) jsel_nxt = 2'd2;
        else st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; jsel_r <= 2'd0;
      col_r <= '0; row_r <= '0; left_mid_r <= '0;
    end else begin
      st_r <= st_nxt; jsel_r <= jsel_nxt;
      if (restart) begin
        col_r <= '0; row_r <= '0;
      end else if (st_r == S_J0 && (!has0 || job_ready)) begin
        if (has0) left_mid_r <= rd_mid_c;
        if (!last_col) begin
          col_r <= c_r + ColW'(1); row_r <= r_r;
        end else begin
          col_r <= '0;
          row_r <= last_row ? '0 : r_r + RowW'(1);
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> st_r == S_RD) else $error("no read cycle");
  a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
    job_valid && job.eof |-> job.last) else $error("eof not last");
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    job_valid |-> {1'b0, job.col} < eff_w) else $error("column range");
`endif

endmodule

[design/wrs_fifo.sv]
// Short job queue between the front and back parts.
// Depends on wrs_pkg.
module wrs_fifo import wrs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_valid,
  output logic wr_ready,
  input  job_t wr_data,
  output logic rd_valid,
  input  logic rd_ready,
  output job_t rd_data
);
  job_t       mem_r [2];
  logic [1:0] cnt_r;
  logic       wp_r, rp_r;
  logic       push, pop;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign push = wr_valid && wr_ready;
  assign pop  = rd_valid && rd_ready;

  always_ff @(posedge clk) if (push) mem_r[wp_r] <= wr_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0; wp_r <= 1'b0; rp_r <= 1'b0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

`ifndef SYNTHESIS
  a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("fifo overflow");
  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 && !rd_ready |=> cnt_r == 2'd2) else $error("fifo lost");
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd0 && !wr_valid |=> !rd_valid) else $error("fifo invent");
`endif
endmodule

[design/wrs_back.sv]
// Back part: three-stage cell arithmetic (neighbor sum, damping product,
// bank product in bank mode, else truncation) with an output register. Depends on wrs_pkg.
module wrs_back import wrs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        job_valid,
  output logic        job_ready,
  input  job_t        job,
  input  logic [15:0] damping,
  input  logic        bank_mode,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data
);
  // One job in flight at a time: the one-hot state walks IDLE, MUL, BANK, OUT.
  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_MUL  = 4'b0010,
    B_BANK = 4'b0100,
    B_OUT  = 4'b1000
  } bst_t;

  bst_t               st_r;
  job_t               job_r;
  logic signed [17:0] h_r;
  logic signed [34:0] p_r;
  logic signed [15:0] res_r;

  logic signed [18:0] sum;
  logic signed [17:0] h_c;
  logic signed [34:0] p_c;
  logic signed [22:0] t;
  logic signed [31:0] q;
  logic signed [34:0] qd;

  assign sum = 19'(job.left) + 19'(job.right) + 19'(job.up) + 19'(job.down);
  assign h_c = 18'(sum >>> 1) - 18'(job.prev);
  assign p_c = h_r * $signed({1'b0, damping});
  assign t   = 23'(p_r >>> 12);
  assign q   = t * $signed({1'b0, job_r.alpha});
  // truncate toward zero: bias negatives before shifting
  assign qd  = p_r + (p_r[34] ? 35'sd65535 : 35'sd0);

  logic signed [31:0] qb;
  assign qb = q + (q[31] ? 32'sd4095 : 32'sd0);

  assign job_ready = (st_r == B_IDLE);
  assign out_valid = (st_r == B_OUT);

  always_comb begin
    out_data = '0;
    out_data.out_col      = job_r.col;
    out_data.out_row      = job_r.row;
    out_data.new_height   = res_r;
    out_data.last_in_run  = job_r.last;
    out_data.end_of_frame = job_r.eof;
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      B_IDLE: if (job_valid) begin job_r <= job; h_r <= h_c; end
      B_MUL:  p_r <= p_c;
      B_BANK: res_r <= bank_mode ? 16'(qb >>> 12) : 16'(qd >>> 16);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= B_IDLE;
    else begin
      unique case (st_r)
        B_IDLE: if (job_valid) st_r <= B_MUL;
        B_MUL:  st_r <= B_BANK;
        B_BANK: st_r <= B_OUT;
        B_OUT:  if (out_ready) st_r <= B_IDLE;
        default: st_r <= B_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == B_MUL |=> st_r == B_BANK) else $error("pipe skipped");
  a_take: assert property (@(posedge clk) disable iff (!rst_n)
    job_valid && job_ready |=> st_r == B_MUL) else $error("job lost");
`endif
endmodule

[design/water_ripple_stencil_step.sv]
// Water ripple stencil step: one generation of the two-buffer ripple.
// Cells enter in raster order; each passes through the front part (accept,
// store read, then the job states) and each result through the back
// arithmetic pipe, which handles one job at a time; on the last row a cell
// makes up to three results. Results for row r-1 come out while row r
// streams in. A write of grid_width or grid_height restarts the frame.
// Depends on wrs_pkg, wrs_front, wrs_fifo, wrs_back.
module water_ripple_stencil_step import wrs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [15:0] cfg_data
);
  logic [10:0] width_r;
  logic [12:0] height_r;
  logic [15:0] damp_r;
  logic        bank_r;
  logic        cfg_wr, restart;
  logic [10:0] eff_w;
  logic [12:0] eff_h;

  assign cfg_ready = 1'b1;
  assign cfg_wr = cfg_valid;
  assign restart = cfg_wr && (cfg_index == REG_GRID_WIDTH ||
                              cfg_index == REG_GRID_HEIGHT);

  // Clamp geometry to the supported range.
  assign eff_w = (width_r < 11'd2) ? 11'd2 :
                 (width_r > 11'(MaxWidth)) ? 11'(MaxWidth) : width_r;
  assign eff_h = (height_r < 13'd2) ? 13'd2 :
                 (height_r > 13'(MaxHeight)) ? 13'(MaxHeight) : height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= 11'd64; height_r <= 13'd64; damp_r <= 16'd61440; bank_r <= 1'b0;
    end else if (cfg_wr) begin
      unique case (reg_idx_t'(cfg_index))
        REG_GRID_WIDTH:  width_r  <= cfg_data[10:0];
        REG_GRID_HEIGHT: height_r <= cfg_data[12:0];
        REG_DAMPING:     damp_r   <= cfg_data;
        REG_BANK_MODE:   bank_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic f_valid, f_ready, b_valid, b_ready;
  job_t f_job, b_job;

  wrs_front u_front (.clk, .rst_n, .in_valid, .in_ready, .in_data,
    .eff_w, .eff_h, .restart, .job_valid(f_valid), .job_ready(f_ready), .job(f_job));

  wrs_fifo u_fifo (.clk, .rst_n, .wr_valid(f_valid), .wr_ready(f_ready),
    .wr_data(f_job), .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_job));

  wrs_back u_back (.clk, .rst_n, .job_valid(b_valid), .job_ready(b_ready),
    .job(b_job), .damping(damp_r), .bank_mode(bank_r),
    .out_valid, .out_ready, .out_data);

`ifndef SYNTHESIS
  a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
    restart |-> cfg_valid) else $error("spurious restart");
  a_eff_w: assert property (@(posedge clk) disable iff (!rst_n)
    eff_w >= 11'd2) else $error("width clamp");
  a_eff_h: assert property (@(posedge clk) disable iff (!rst_n)
    eff_h >= 13'd2) else $error("height clamp");
`endif
endmodule
